// ===== rtl/seqa_pkg.sv =====
// ----------------------------------------------------------------------------
// seqa_pkg
// Shared types and constants of the spike event queue accumulator: queue
// sizing, field widths, command and status codes, state and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package seqa_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int CMD_W    = 2;
   localparam int SYN_W    = 16;
   localparam int TIME_W   = 32;
   localparam int WEIGHT_W = 16;
   localparam int INV_W    = 17;
   localparam int ACT_W    = 48;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = TIME_W + WEIGHT_W;

   // due-weight sum and its product with the reciprocal step
   localparam int SUM_W  = IDX_W + WEIGHT_W;
   localparam int PROD_W = SUM_W + INV_W + 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = INV_W;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADIDX = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_SYNAPSES = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_STEP     = 1'b1;

   localparam logic [INV_W-1:0] INV_STEP_RESET = 17'd1000;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DRAIN,
      S_MUL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic drain_en;
      logic mul_en;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic drain_done;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== rtl/seqa_if.sv =====
// ----------------------------------------------------------------------------
// seqa_if
// Channel interfaces: request, response and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface seqa_req_if
   import seqa_pkg::*;
   ;
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           command;
   logic [SYN_W-1:0]           synapse_index;
   logic [TIME_W-1:0]          spike_time;
   logic signed [WEIGHT_W-1:0] spike_weight;
   logic [TIME_W-1:0]          current_time;

   modport source (output valid, command, synapse_index, spike_time, spike_weight,
                   current_time, input ready);
   modport sink (input valid, command, synapse_index, spike_time, spike_weight,
                 current_time, output ready);
endinterface

interface seqa_rsp_if
   import seqa_pkg::*;
   ;
   logic                    valid;
   logic                    ready;
   logic signed [ACT_W-1:0] activation;
   logic                    fired;
   logic [STATUS_W-1:0]     status;

   modport source (output valid, activation, fired, status, input ready);
   modport sink (input valid, activation, fired, status, output ready);
endinterface

interface seqa_csr_if
   import seqa_pkg::*;
   ;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/seqa_ram.sv =====
// ----------------------------------------------------------------------------
// seqa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module seqa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/seqa_ctrl.sv =====
// ----------------------------------------------------------------------------
// seqa_ctrl
// Sequencer: accepts a request, runs the drain loop for a tick, then the
// multiply, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module seqa_ctrl
   import seqa_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = stat.is_tick ? S_DRAIN : S_DONE;
            end
         end
         S_DRAIN: begin
            if (stat.drain_done) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_DRAIN: begin
            cmd.drain_en = 1'b1;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
         end
         S_DONE: begin
            cmd.load_out = stat.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/seqa_dp.sv =====
// ----------------------------------------------------------------------------
// seqa_dp
// Datapath: configuration registers, event store, drain and compaction,
// weight accumulation, multiply and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module seqa_dp
   import seqa_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   seqa_req_if.sink     req,
   seqa_rsp_if.source   rsp,
   seqa_csr_if.sink     csr,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat
);

   logic [SYN_W-1:0]  num_syn_ff;
   logic [INV_W-1:0]  inv_step_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [ACT_W-1:0]  res_act_ff, res_act_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;
   logic                     rsp_valid_ff;
   logic signed [ACT_W-1:0]  rsp_act_ff;
   logic                     rsp_fired_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;

   logic               rd_issue;
   logic               entry_due;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               add_ok;
   logic signed [PROD_W-1:0] prod;

   // register writes
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_syn_ff  <= '0;
         inv_step_ff <= INV_STEP_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            REG_NUM_SYNAPSES: num_syn_ff  <= csr.data[SYN_W-1:0];
            REG_INV_STEP:     inv_step_ff <= csr.data;
            default:          num_syn_ff  <= num_syn_ff;
         endcase
      end
   end

   seqa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rd_issue  = cmd.drain_en && (rd_idx_ff < count_ff);
   assign entry_due = ram_rd_data[ENTRY_W-1:WEIGHT_W] <= now_ff;
   assign add_ok    = (req.synapse_index < num_syn_ff)
                      && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign prod      = PROD_W'(sum_ff) * PROD_W'($signed({1'b0, inv_step_ff}));

   // in-place compaction: kept entries are rewritten at or below the read point
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[IDX_W-1:0];
      ram_wr_data = {req.spike_time, req.spike_weight};
      if (cmd.accept) begin
         ram_wr_en = (req.command == CMD_ADD) && add_ok;
      end else if (rd_valid_ff && !entry_due) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = kept_ff[IDX_W-1:0];
         ram_wr_data = ram_rd_data;
      end
   end

   always_comb begin
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      kept_in       = kept_ff;
      rd_valid_in   = rd_issue;
      now_in        = now_ff;
      sum_in        = sum_ff;
      res_act_in    = res_act_ff;
      res_status_in = res_status_ff;
      if (cmd.accept) begin
         rd_idx_in     = '0;
         kept_in       = '0;
         sum_in        = '0;
         res_act_in    = '0;
         res_status_in = ST_OK;
         now_in        = req.current_time;
         case (req.command)
            CMD_ADD: begin
               if (req.synapse_index >= num_syn_ff) begin
                  res_status_in = ST_BADIDX;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  res_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end else begin
         if (rd_issue) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            if (entry_due) begin
               sum_in = sum_ff + SUM_W'($signed(ram_rd_data[WEIGHT_W-1:0]));
            end else begin
               kept_in = kept_ff + 1'b1;
            end
         end
         if (cmd.mul_en) begin
            count_in   = kept_ff;
            res_act_in = ACT_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      kept_ff       <= kept_in;
      now_ff        <= now_in;
      sum_ff        <= sum_in;
      res_act_ff    <= res_act_in;
      res_status_ff <= res_status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_act_ff    <= res_act_ff;
         rsp_fired_ff  <= (res_act_ff != '0);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.activation = rsp_act_ff;
   assign rsp.fired      = rsp_fired_ff;
   assign rsp.status     = rsp_status_ff;

   assign stat.is_tick    = (req.command == CMD_TICK);
   assign stat.drain_done = !(rd_idx_ff < count_ff) && !rd_valid_ff;
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

endmodule

`default_nettype wire

// ===== rtl/spike_event_queue_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// spike_event_queue_accumulator_top
// Time-ordered spike event queue with tick-driven weight accumulation.
// ----------------------------------------------------------------------------
// An add request writes its event into a 64-entry store, and its result
// then goes from the done state to the output register. A clear request
// takes the same path. A tick request passes through the drain and
// multiply states before the done state. The single read port of the
// event store scans one entry a cycle. Due weights are summed and the
// rest are packed down in place. The scan is finished once the last read
// has returned from the registered read data. The multiply state then
// multiplies the sum by inv_step. A new request is taken while a response
// still waits in the output register. A request's done state stalls until
// that response leaves. Register writes are always taken and must happen
// only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_event_queue_accumulator_top
   import seqa_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   seqa_req_if.sink   req,
   seqa_rsp_if.source rsp,
   seqa_csr_if.sink   csr
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   seqa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   seqa_dp u_dp (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire
